>>> sv/ipv4_tcp_checksum_engine_assert.svh
// Assertion macros for the IPv4/TCP checksum engine.
// Included by the top level; no other dependencies.
`ifndef IPV4_TCP_CHECKSUM_ENGINE_ASSERT_SVH
`define IPV4_TCP_CHECKSUM_ENGINE_ASSERT_SVH

// same-cycle implication
`define ITC_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("checksum engine: same-cycle implication failed");

// next-cycle implication
`define ITC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("checksum engine: next-cycle implication failed");

`endif

>>> sv/itc_pkg.sv
// Shared types, constants and the ones-complement adder for the checksum engine.
// No dependencies.
package itc_pkg;

   typedef struct packed {
      logic [15:0] word;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] ip_checksum;
      logic [15:0] tcp_checksum;
      logic        length_error;
   } rsp_type;

   localparam logic [7:0]  PROTO_RESET     = 8'd6;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [15:0] IP_CSUM_WORD    = 16'd5;
   localparam logic [15:0] PSEUDO_FIRST    = 16'd6;
   localparam logic [15:0] PSEUDO_LAST     = 16'd9;
   localparam logic [5:0]  TCP_CSUM_OFFSET = 6'd8;
   localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

   // ones-complement add with end-around carry
   function automatic logic [15:0] sum1c(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

>>> sv/itc_accum.sv
// Per-packet accumulator: header length, total length, running IP and TCP sums.
// Depends on itc_pkg.
module itc_accum (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  itc_pkg::req_type beat,
   input  logic [7:0]      proto,
   output itc_pkg::rsp_type result
);
   import itc_pkg::*;

   logic [15:0] word_index_ff, word_index_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] ip_sum_ff, ip_sum_in;
   logic [15:0] tcp_sum_ff, tcp_sum_in;
   logic        short_flag_ff, short_flag_in;

   logic [3:0]  eff;
   logic [4:0]  hdr;
   logic [5:0]  quad;
   logic [5:0]  skip_idx;
   logic        in_hdr;
   logic [16:0] byte_pos;
   logic [15:0] seg_word;
   logic [15:0] seglen;
   logic [16:0] tl_plus;
   logic [15:0] needed;
   logic [15:0] pseudo_sum;
   logic        err;

   always_comb begin
      header_words_in = (word_index_ff == 16'd0) ? beat.word[11:8] : header_words_ff;
      eff  = (header_words_in < MIN_IHL) ? MIN_IHL : header_words_in;
      hdr  = {eff, 1'b0};
      quad = {eff, 2'b00};

      if (word_index_ff == 16'd1) begin
         total_length_in = beat.word;
         short_flag_in   = beat.word < {10'd0, quad};
      end else begin
         total_length_in = total_length_ff;
         short_flag_in   = short_flag_ff;
      end

      in_hdr   = word_index_ff < {11'd0, hdr};
      byte_pos = {word_index_ff, 1'b0};
      skip_idx = {1'b0, hdr} + TCP_CSUM_OFFSET;
      // odd total length: keep only the upper byte of the final segment word
      seg_word = (byte_pos + 17'd1 == {1'b0, total_length_in}) ?
                 {beat.word[15:8], 8'h00} : beat.word;

      ip_sum_in  = ip_sum_ff;
      tcp_sum_in = tcp_sum_ff;
      if (in_hdr) begin
         if (word_index_ff != IP_CSUM_WORD)
            ip_sum_in = sum1c(ip_sum_ff, beat.word);
         if (word_index_ff >= PSEUDO_FIRST && word_index_ff <= PSEUDO_LAST)
            tcp_sum_in = sum1c(tcp_sum_ff, beat.word);
      end else if (byte_pos < {1'b0, total_length_in} &&
                   word_index_ff != {10'd0, skip_idx}) begin
         tcp_sum_in = sum1c(tcp_sum_ff, seg_word);
      end

      word_index_in = (word_index_ff == INDEX_MAX) ? word_index_ff : word_index_ff + 16'd1;

      seglen  = (total_length_in >= {10'd0, quad}) ? total_length_in - {10'd0, quad} : 16'd0;
      tl_plus = {1'b0, total_length_in} + 17'd1;
      needed  = (tl_plus[16:1] < {11'd0, hdr}) ? {11'd0, hdr} : tl_plus[16:1];
      err     = (header_words_in < MIN_IHL) || short_flag_in || (word_index_in < needed);

      // protocol and segment length folded beside the running sum, end-around add
      // is associative so only one add follows the segment sum
      pseudo_sum = sum1c({8'd0, proto}, seglen);
      result.ip_checksum  = ~ip_sum_in;
      result.tcp_checksum = ~sum1c(tcp_sum_in, pseudo_sum);
      result.length_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && beat.last)) begin
         word_index_ff   <= '0;
         header_words_ff <= '0;
         total_length_ff <= '0;
         ip_sum_ff       <= '0;
         tcp_sum_ff      <= '0;
         short_flag_ff   <= 1'b0;
      end else if (step) begin
         word_index_ff   <= word_index_in;
         header_words_ff <= header_words_in;
         total_length_ff <= total_length_in;
         ip_sum_ff       <= ip_sum_in;
         tcp_sum_ff      <= tcp_sum_in;
         short_flag_ff   <= short_flag_in;
      end
   end

endmodule

>>> sv/ipv4_tcp_checksum_engine.sv
// Channel   Direction  Payload
// req_      in         itc_pkg::req_type  (word, last)
// rsp_      out        itc_pkg::rsp_type  (ip_checksum, tcp_checksum, length_error)
// csr_      in         pseudo header protocol byte, write only
//
// One word accepted every cycle while req_stall is low. A taken last word passes
// the input register, then one add-and-fold pass into the result register.
// Synchronous reset clears packet state and sets the protocol byte to 6.
// req_stall rises only when a last beat waits behind a stalled, full result register.
// Top level of the IPv4/TCP checksum engine; depends on itc_pkg, itc_accum and
// ipv4_tcp_checksum_engine_assert.svh.
`include "ipv4_tcp_checksum_engine_assert.svh"

module ipv4_tcp_checksum_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  itc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output itc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import itc_pkg::*;

   logic    beat_valid_ff;
   req_type beat_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic [7:0] proto_ff;
   logic    step;
   rsp_type result;

   assign req_stall = beat_valid_ff && beat_ff.last && rsp_valid_ff && rsp_stall;
   assign step      = beat_valid_ff && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   itc_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (beat_ff),
      .proto  (proto_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         proto_ff      <= PROTO_RESET;
      end else begin
         if (csr_wr_en)
            proto_ff <= csr_wr_data;
         if (!req_stall)
            beat_valid_ff <= req_valid;
         if (step && beat_ff.last)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall)
         beat_ff <= req_data;
      if (step && beat_ff.last)
         rsp_data_ff <= result;
   end

   `ITC_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid_ff && rsp_stall && beat_ff.last)
   `ITC_ASSERT_NEXT(a_last_loads, clock, reset, step && beat_ff.last, rsp_valid_ff)
   `ITC_ASSERT_IMP(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff), $past(step && beat_ff.last))

endmodule
